[sv/cga_pkg.sv]
// Shared widths and the pipeline item type of the central gravity acceleration unit.
`default_nettype none
package cga_pkg;

  // Coordinate and GM formats.
  localparam int CW   = 32;            // coordinate width, 16 fraction bits
  localparam int GW   = 48;            // GM width, unsigned Q32.16
  localparam int GH   = GW / 2;        // GM split point for the numerator products
  localparam int MW   = CW;            // magnitude of a difference
  localparam int SW   = 2 * CW + 2;    // sum of three squares
  localparam int RADW = SW + 64;       // root radicand, S scaled by 2^64
  localparam int RW   = RADW / 2;      // norm with 48 fraction bits
  localparam int SL   = SW / 2;        // split of S for the denominator products
  localparam int RL   = RW / 2;        // split of R for the denominator products
  localparam int PPW  = (SW - SL) + (RW - RL);
  localparam int DENW = SW + RW;       // S times R
  localparam int PW   = MW + GW;       // |D| times GM
  localparam int EXW  = PW + 64 - CW;  // numerator over 2^CW
  localparam int QW   = CW;            // quotient bits kept

  // Configuration register indexes.
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 2'd2;
  localparam logic [CFG_IW-1:0] REG_GM       = 2'd3;

  // Pipeline stage positions.
  localparam int ST_SQ0 = 4;
  localparam int ST_PP  = ST_SQ0 + RW;
  localparam int ST_DEN = ST_PP + 1;
  localparam int ST_INI = ST_DEN + 1;
  localparam int ST_DV0 = ST_INI + 1;
  localparam int NS     = ST_DV0 + QW;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic [2:0][MW-1:0]    mag;
    logic [2:0]            neg;
    logic [2:0][2*MW-1:0]  sq;
    logic [2:0][MW+GH-1:0] nplo;
    logic [2:0][MW+GH-1:0] nphi;
    logic [2:0][PW-1:0]    prod;
    logic [SW-1:0]         s;
    logic                  coin;
    logic [RADW-1:0]       rad;
    logic [RW-1:0]         root;
    logic [RW+1:0]         srem;
    logic [3:0][PPW-1:0]   pp;
    logic [DENW-1:0]       den;
    logic [2:0]            ovf;
    logic [2:0][DENW-1:0]  drem;
    logic [2:0][QW-1:0]    q;
    logic [2:0][CW-1:0]    acc;
    logic                  sat;
  } cga_item_t;

endpackage
`default_nettype wire

[sv/cga_core.sv]
// Arithmetic pipeline: difference, squares, norm root, denominator, division, saturation.
`default_nettype none
module cga_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0][cga_pkg::CW-1:0]    pos,
  input  wire logic [2:0][cga_pkg::CW-1:0]    origin,
  input  wire logic [cga_pkg::GW-1:0]         gm,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0][cga_pkg::CW-1:0]         acc,
  output logic                                coincident,
  output logic                                saturated
);
  import cga_pkg::*;

  cga_item_t   pipe [1:NS];
  cga_item_t   nxt  [1:NS];
  logic [NS:1] vld;
  logic        adv;

  // The whole pipeline moves whenever the output register is free or being emptied.
  assign adv      = !vld[NS] || out_ready;
  assign in_ready = adv;

  // Stage 1: signed difference from the position to the origin, as sign and magnitude.
  always_comb begin
    logic [CW:0] d;
    logic [CW:0] nd;
    nxt[1] = '0;
    for (int i = 0; i < 3; i++) begin
      d  = {origin[i][CW-1], origin[i]} - {pos[i][CW-1], pos[i]};
      nd = -d;
      nxt[1].neg[i] = d[CW];
      nxt[1].mag[i] = d[CW] ? nd[CW-1:0] : d[CW-1:0];
    end
  end

  // Stage 2: squares and the two halves of each numerator product.
  always_comb begin
    nxt[2] = pipe[1];
    for (int i = 0; i < 3; i++) begin
      nxt[2].sq[i]   = pipe[1].mag[i] * pipe[1].mag[i];
      nxt[2].nplo[i] = pipe[1].mag[i] * gm[GH-1:0];
      nxt[2].nphi[i] = pipe[1].mag[i] * gm[GW-1:GH];
    end
  end

  // Stage 3: sum of squares, numerators, and the start of the root recurrence.
  always_comb begin
    logic [SW-1:0] sum;
    nxt[3] = pipe[2];
    sum = SW'(pipe[2].sq[0]) + SW'(pipe[2].sq[1]) + SW'(pipe[2].sq[2]);
    for (int i = 0; i < 3; i++) begin
      nxt[3].prod[i] = PW'(pipe[2].nplo[i]) + (PW'(pipe[2].nphi[i]) << GH);
    end
    nxt[3].s    = sum;
    nxt[3].coin = (sum == '0);
    nxt[3].rad  = {sum, 64'd0};
    nxt[3].root = '0;
    nxt[3].srem = '0;
  end

  // Root stages: one result bit of floor(sqrt(S * 2^64)) per stage.
  for (genvar k = ST_SQ0; k < ST_PP; k++) begin : g_sqrt
    always_comb begin
      logic [RW+3:0] t;
      logic [RW+3:0] trial;
      logic [RW+3:0] diff;
      logic          ge;
      nxt[k] = pipe[k-1];
      t      = {pipe[k-1].srem, pipe[k-1].rad[RADW-1 -: 2]};
      trial  = {2'b00, pipe[k-1].root, 2'b01};
      ge     = (t >= trial);
      diff   = t - trial;
      nxt[k].srem = ge ? diff[RW+1:0] : t[RW+1:0];
      nxt[k].root = {pipe[k-1].root[RW-2:0], ge};
      nxt[k].rad  = pipe[k-1].rad << 2;
    end
  end

  // Denominator partial products of S times R.
  always_comb begin
    nxt[ST_PP] = pipe[ST_PP-1];
    nxt[ST_PP].pp[0] = pipe[ST_PP-1].s[SL-1:0]  * pipe[ST_PP-1].root[RL-1:0];
    nxt[ST_PP].pp[1] = pipe[ST_PP-1].s[SL-1:0]  * pipe[ST_PP-1].root[RW-1:RL];
    nxt[ST_PP].pp[2] = pipe[ST_PP-1].s[SW-1:SL] * pipe[ST_PP-1].root[RL-1:0];
    nxt[ST_PP].pp[3] = pipe[ST_PP-1].s[SW-1:SL] * pipe[ST_PP-1].root[RW-1:RL];
  end

  // Denominator sum.
  always_comb begin
    nxt[ST_DEN] = pipe[ST_DEN-1];
    nxt[ST_DEN].den = DENW'(pipe[ST_DEN-1].pp[0])
                    + (DENW'(pipe[ST_DEN-1].pp[1]) << RL)
                    + (DENW'(pipe[ST_DEN-1].pp[2]) << SL)
                    + (DENW'(pipe[ST_DEN-1].pp[3]) << (SL + RL));
  end

  // Overflow test against 2^QW and the starting partial remainder of each division.
  always_comb begin
    logic [DENW-1:0] wide;
    nxt[ST_INI] = pipe[ST_INI-1];
    for (int i = 0; i < 3; i++) begin
      wide = DENW'({pipe[ST_INI-1].prod[i], {(64-CW){1'b0}}});
      nxt[ST_INI].ovf[i]  = (wide >= pipe[ST_INI-1].den);
      nxt[ST_INI].drem[i] = wide;
      nxt[ST_INI].q[i]    = '0;
    end
  end

  // Division stages: one quotient bit per stage for each component.
  for (genvar k = ST_DV0; k < NS; k++) begin : g_div
    always_comb begin
      logic [DENW:0] t;
      logic [DENW:0] diff;
      logic          ge;
      nxt[k] = pipe[k-1];
      for (int i = 0; i < 3; i++) begin
        t    = {pipe[k-1].drem[i], 1'b0};
        ge   = (t >= {1'b0, pipe[k-1].den});
        diff = t - {1'b0, pipe[k-1].den};
        nxt[k].drem[i] = ge ? diff[DENW-1:0] : t[DENW-1:0];
        nxt[k].q[i]    = {pipe[k-1].q[i][QW-2:0], ge};
      end
    end
  end

  // Final stage: clip, apply the sign, and handle a coincident position.
  always_comb begin
    logic [QW-1:0] mval;
    logic          clip;
    logic          any;
    nxt[NS] = pipe[NS-1];
    any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (pipe[NS-1].neg[i]) begin
        clip = pipe[NS-1].ovf[i] || (pipe[NS-1].q[i] > {1'b1, {(QW-1){1'b0}}});
        mval = clip ? {1'b1, {(QW-1){1'b0}}} : pipe[NS-1].q[i];
      end else begin
        clip = pipe[NS-1].ovf[i] || (pipe[NS-1].q[i] > {1'b0, {(QW-1){1'b1}}});
        mval = clip ? {1'b0, {(QW-1){1'b1}}} : pipe[NS-1].q[i];
      end
      any = any | clip;
      if (pipe[NS-1].coin) begin
        nxt[NS].acc[i] = '0;
      end else begin
        nxt[NS].acc[i] = pipe[NS-1].neg[i] ? -mval : mval;
      end
    end
    nxt[NS].sat = any && !pipe[NS-1].coin;
  end

  // Payload registers advance together with the valid bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= NS; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:1], in_valid};
    end
  end

  assign out_valid  = vld[NS];
  assign acc        = pipe[NS].acc;
  assign coincident = pipe[NS].coin;
  assign saturated  = pipe[NS].sat;

endmodule
`default_nettype wire

[sv/central_gravity_accel_unit.sv]
// Top level of the central gravity acceleration unit: ports, configuration registers, packing.
`default_nettype none
// Each query position transfer yields one acceleration transfer, a = d * GM / |d|^3 with
// d running from the position to the configured origin, in signed Q16.16 clipped to range.
// One position is taken every cycle while the result side is not stalled; each result
// passes through the 65-step norm root and the 32-step quotient recurrence. Stalls on
// the result side hold the whole pipeline without loss. A position equal to the origin
// gives zero acceleration with the coincident flag; saturated marks any clipped component.
// Configuration writes belong in idle periods and always complete at once.
module central_gravity_accel_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Query positions.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [3*cga_pkg::CW-1:0]    s_tdata,   // pos_x, pos_y, pos_z
  // Accelerations.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [3*cga_pkg::CW-1:0]         m_tdata,   // acc_x, acc_y, acc_z
  output logic [1:0]                       m_tuser,   // coincident, saturated
  // Configuration writes.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cga_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [cga_pkg::GW-1:0]      cfg_data
);
  import cga_pkg::*;

  logic [2:0][CW-1:0] origin;
  logic [GW-1:0]      gm;
  logic [2:0][CW-1:0] acc;
  logic               coincident;
  logic               saturated;

  assign cfg_ready = 1'b1;

  // Register writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      gm     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0] <= cfg_data[CW-1:0];
        REG_ORIGIN_Y: origin[1] <= cfg_data[CW-1:0];
        REG_ORIGIN_Z: origin[2] <= cfg_data[CW-1:0];
        REG_GM:       gm        <= cfg_data;
        default: ;
      endcase
    end
  end

  cga_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pos        (s_tdata),
    .origin     (origin),
    .gm         (gm),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .acc        (acc),
    .coincident (coincident),
    .saturated  (saturated)
  );

  // Result packing.
  assign m_tdata = acc;
  assign m_tuser = {saturated, coincident};

endmodule
`default_nettype wire
